>>> rtl/cbgt_pkg.sv
package cbgt_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_ACCUM    = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  // Result kinds carried on out_tuser
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes
  localparam logic REG_FILL_GAIN   = 1'b0;
  localparam logic REG_FILL_PASSES = 1'b1;

  localparam logic [15:0] FILL_GAIN_RESET   = 16'd29491;
  localparam logic [5:0]  FILL_PASSES_RESET = 6'd36;

  localparam int SUM_W      = 40;
  localparam int MEAN_W     = 17;
  localparam int CNT_W      = 32;
  localparam int TAG_W      = 6;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 80;

  localparam logic [MEAN_W-1:0] MEAN_LIMIT = 17'd65280;

  typedef struct packed {
    logic              kind;
    logic              table_ready;
    logic [MEAN_W-1:0] row_grad_mean;
    logic [MEAN_W-1:0] col_grad_mean;
    logic [CNT_W-1:0]  sample_total;
    logic [TAG_W-1:0]  filled_in_pass;
  } res_t;

endpackage

>>> rtl/color_bin_gradient_table.sv
// One request at a time. Accumulate goes through accept, read and write back (an accumulate
// is ignored once the table is ready); a read result passes through address, data and emit
// steps, and clear sweeps all BINS^3 entries. Finalize divides each counted bin's row then
// column sum by its count on one shared 48-step divider and skips empty bins, then per fill
// pass probes up to 8 diagonal neighbors per hole and scales by the gain; a finalize on a
// ready table skips the walk. Reset (rst_n, synchronous): a clearing pass over all BINS^3
// entries (1728 at BINS=12) zeroes every store while in_tready stays low; config writes are taken during it.
module color_bin_gradient_table #(
  parameter int BINS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, low bit up: raw_red, raw_green, raw_blue, back_red, back_green, back_blue,
  //   depth_here, depth_below, depth_right, entry_index, zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cbgt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,   // op
  // out_tdata, low bit up: table_ready, row_grad_mean, col_grad_mean, sample_total,
  //   filled_in_pass, zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cbgt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // result_kind
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [15:0]                     cfg_data
);

  localparam int ENTRIES = BINS * BINS * BINS;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(BINS);
  localparam logic [AW-1:0] BINS_AW  = AW'(BINS);
  localparam logic [AW-1:0] LAST_LIN = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] LAST_BIN = CW'(BINS - 1);
  localparam logic [12:0]   ENTRIES_13 = 13'(ENTRIES);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ACC_RD  = 5'd2;
  localparam logic [4:0] S_ACC_WR  = 5'd3;
  localparam logic [4:0] S_RD_RD   = 5'd4;
  localparam logic [4:0] S_RD_DATA = 5'd5;
  localparam logic [4:0] S_MN_RD   = 5'd6;
  localparam logic [4:0] S_MN_LD   = 5'd7;
  localparam logic [4:0] S_DIVR    = 5'd8;
  localparam logic [4:0] S_ROWEND  = 5'd9;
  localparam logic [4:0] S_DIVC    = 5'd10;
  localparam logic [4:0] S_COLEND  = 5'd11;
  localparam logic [4:0] S_FL_RD   = 5'd12;
  localparam logic [4:0] S_FL_CHK  = 5'd13;
  localparam logic [4:0] S_NB_ADDR = 5'd14;
  localparam logic [4:0] S_NB_CHK  = 5'd15;
  localparam logic [4:0] S_MUL_A   = 5'd16;
  localparam logic [4:0] S_MUL_B   = 5'd17;
  localparam logic [4:0] S_FL_WR   = 5'd18;
  localparam logic [4:0] S_FDONE   = 5'd19;
  localparam logic [4:0] S_EMIT    = 5'd20;

  // Table stores
  logic [39:0] row_mem [ENTRIES];
  logic [39:0] col_mem [ENTRIES];
  logic [31:0] cnt_mem [ENTRIES];
  logic [5:0]  tag_mem [ENTRIES];

  logic [39:0] row_q, col_q;
  logic [31:0] cnt_q;
  logic [5:0]  tag_q;

  logic [AW-1:0] rd_addr, wr_addr;
  logic          we_sum, we_cnt, we_tag;
  logic [39:0]   wd_row, wd_col;
  logic [31:0]   wd_cnt;
  logic [5:0]    wd_tag;

  logic [4:0]    state_r, state_nxt;
  logic [AW-1:0] lin_r, lin_nxt;
  logic [CW-1:0] r_r, r_nxt, g_r, g_nxt, b_r, b_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [5:0]    pass_r, pass_nxt;
  logic [82:0]   in_r, in_nxt;
  logic [47:0]   div_q_r, div_q_nxt;
  logic [31:0]   div_rem_r, div_rem_nxt;
  logic [5:0]    div_cnt_r, div_cnt_nxt;
  logic [31:0]   dvsr_r, dvsr_nxt;
  logic          neg_r, neg_nxt;
  logic [39:0]   col_hold_r, col_hold_nxt;
  logic [39:0]   row_mean_r, row_mean_nxt;
  logic [16:0]   opa_r, opa_nxt, opb_r, opb_nxt;
  logic signed [33:0] prod_r, prod_nxt;
  logic [16:0]   fill_row_r, fill_row_nxt;
  cbgt_pkg::res_t res_r, res_nxt;
  logic          out_valid_r;
  cbgt_pkg::res_t out_r;
  logic          ready_flag_r, ready_flag_nxt;
  logic [15:0]   gain_r;
  logic [5:0]    passes_r;

  // Field views of the held request
  logic [7:0]  raw_red, raw_green, raw_blue, back_red, back_green, back_blue;
  logic [7:0]  depth_here, depth_below, depth_right;
  logic [10:0] entry_index;

  assign raw_red     = in_r[7:0];
  assign raw_green   = in_r[15:8];
  assign raw_blue    = in_r[23:16];
  assign back_red    = in_r[31:24];
  assign back_green  = in_r[39:32];
  assign back_blue   = in_r[47:40];
  assign depth_here  = in_r[55:48];
  assign depth_below = in_r[63:56];
  assign depth_right = in_r[71:64];
  assign entry_index = in_r[82:72];

  function automatic logic [CW-1:0] bin_of(input logic [7:0] raw, input logic [7:0] back);
    logic [9:0]  s;
    logic [13:0] p;
    s = 10'(raw) + 10'd256 - 10'(back);
    p = 14'(s) * 14'(BINS);
    return CW'(p >> 9);
  endfunction

  function automatic logic [AW-1:0] idx_of(input logic [CW-1:0] r, input logic [CW-1:0] g,
                                           input logic [CW-1:0] b);
    return (AW'(r) * BINS_AW + AW'(g)) * BINS_AW + AW'(b);
  endfunction

  // Clamp a quotient magnitude and restore the sign
  function automatic logic [39:0] mean_finish(input logic [47:0] q, input logic neg);
    logic [16:0] mag;
    mag = (q > 48'(cbgt_pkg::MEAN_LIMIT)) ? cbgt_pkg::MEAN_LIMIT : q[16:0];
    return neg ? (40'd0 - {23'd0, mag}) : {23'd0, mag};
  endfunction

  // Q15 product to mean: truncate toward zero, then clamp
  function automatic logic [16:0] fill_scale(input logic signed [33:0] p);
    logic signed [33:0] adj;
    logic signed [18:0] q;
    adj = p + (p[33] ? 34'sd32767 : 34'sd0);
    q   = 19'(adj >>> 15);
    if (q > 19'sd65280) begin
      return cbgt_pkg::MEAN_LIMIT;
    end else if (q < -19'sd65280) begin
      return 17'd0 - cbgt_pkg::MEAN_LIMIT;
    end else begin
      return q[16:0];
    end
  endfunction

  function automatic logic [39:0] sext_mean(input logic [16:0] v);
    return {{23{v[16]}}, v};
  endfunction

  function automatic logic [39:0] sat_add(input logic [39:0] s, input logic [9:0] d);
    logic [40:0] t;
    t = {s[39], s} + {{31{d[9]}}, d};
    if (t[40] != t[39]) begin
      return t[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      return t[39:0];
    end
  endfunction

  // Accumulate address and depth differences
  logic [AW-1:0] acc_idx;
  logic [9:0]    row_delta, col_delta;

  assign acc_idx   = idx_of(bin_of(raw_red, back_red), bin_of(raw_green, back_green),
                            bin_of(raw_blue, back_blue));
  assign row_delta = {2'b00, depth_below} - {2'b00, depth_here};
  assign col_delta = {2'b00, depth_right} - {2'b00, depth_here};

  // Shared divider step
  logic [32:0] div_trial, div_diff;
  logic        div_ge;
  logic [31:0] div_rem_step;
  logic [47:0] div_q_step;

  assign div_trial    = {div_rem_r, div_q_r[47]};
  assign div_diff     = div_trial - {1'b0, dvsr_r};
  assign div_ge       = div_trial >= {1'b0, dvsr_r};
  assign div_rem_step = div_ge ? div_diff[31:0] : div_trial[31:0];
  assign div_q_step   = {div_q_r[46:0], div_ge};

  // Shared multiplier
  logic signed [16:0] mul_in, gain_s;
  logic signed [33:0] mul_out;

  assign mul_in  = (state_r == S_MUL_A) ? $signed(opa_r) : $signed(opb_r);
  assign gain_s  = $signed({1'b0, gain_r});
  assign mul_out = mul_in * gain_s;

  // Fill walk coordinates
  logic [AW-1:0] here_idx, nb_idx;
  logic [CW-1:0] nr, ng, nbb;
  logic          nb_in_bounds, bin_last;

  assign here_idx = idx_of(r_r, g_r, b_r);
  assign nr  = k_r[2] ? CW'(r_r + 1'b1) : CW'(r_r - 1'b1);
  assign ng  = k_r[1] ? CW'(g_r + 1'b1) : CW'(g_r - 1'b1);
  assign nbb = k_r[0] ? CW'(b_r + 1'b1) : CW'(b_r - 1'b1);
  assign nb_idx = idx_of(nr, ng, nbb);
  assign nb_in_bounds = (k_r[2] ? (r_r != LAST_BIN) : (r_r != '0)) &&
                        (k_r[1] ? (g_r != LAST_BIN) : (g_r != '0)) &&
                        (k_r[0] ? (b_r != LAST_BIN) : (b_r != '0));
  assign bin_last = (r_r == LAST_BIN) && (g_r == LAST_BIN) && (b_r == LAST_BIN);

  logic adv_bin;

  always_comb begin
    state_nxt      = state_r;
    lin_nxt        = lin_r;
    r_nxt          = r_r;
    g_nxt          = g_r;
    b_nxt          = b_r;
    k_nxt          = k_r;
    pass_nxt       = pass_r;
    in_nxt         = in_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_cnt_nxt    = div_cnt_r;
    dvsr_nxt       = dvsr_r;
    neg_nxt        = neg_r;
    col_hold_nxt   = col_hold_r;
    row_mean_nxt   = row_mean_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    prod_nxt       = prod_r;
    fill_row_nxt   = fill_row_r;
    res_nxt        = res_r;
    ready_flag_nxt = ready_flag_r;
    rd_addr        = lin_r;
    wr_addr        = lin_r;
    we_sum         = 1'b0;
    we_cnt         = 1'b0;
    we_tag         = 1'b0;
    wd_row         = '0;
    wd_col         = '0;
    wd_cnt         = '0;
    wd_tag         = '0;
    adv_bin        = 1'b0;

    unique case (state_r)
      S_CLR: begin
        we_sum = 1'b1;
        we_cnt = 1'b1;
        we_tag = 1'b1;
        lin_nxt = AW'(lin_r + 1'b1);
        if (lin_r == LAST_LIN) begin
          lin_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          in_nxt = in_tdata[82:0];
          unique case (in_tuser)
            cbgt_pkg::OP_ACCUM: begin
              state_nxt = ready_flag_r ? S_IDLE : S_ACC_RD;
            end
            cbgt_pkg::OP_FINALIZE: begin
              lin_nxt   = '0;
              state_nxt = ready_flag_r ? S_FDONE : S_MN_RD;
            end
            cbgt_pkg::OP_READ: begin
              state_nxt = S_RD_RD;
            end
            cbgt_pkg::OP_CLEAR: begin
              ready_flag_nxt = 1'b0;
              lin_nxt        = '0;
              state_nxt      = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACC_RD: begin
        rd_addr   = acc_idx;
        state_nxt = S_ACC_WR;
      end
      S_ACC_WR: begin
        wr_addr   = acc_idx;
        we_sum    = 1'b1;
        we_cnt    = 1'b1;
        wd_row    = sat_add(row_q, row_delta);
        wd_col    = sat_add(col_q, col_delta);
        wd_cnt    = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
        state_nxt = S_IDLE;
      end
      S_RD_RD: begin
        rd_addr   = AW'(entry_index);
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_nxt = '0;
        res_nxt.kind        = cbgt_pkg::KIND_READ;
        res_nxt.table_ready = ready_flag_r;
        if ({2'b00, entry_index} < ENTRIES_13) begin
          if (ready_flag_r) begin
            res_nxt.row_grad_mean = row_q[16:0];
            res_nxt.col_grad_mean = col_q[16:0];
          end
          res_nxt.sample_total   = cnt_q;
          res_nxt.filled_in_pass = tag_q;
        end
        state_nxt = S_EMIT;
      end
      S_MN_RD: begin
        rd_addr   = lin_r;
        state_nxt = S_MN_LD;
      end
      S_MN_LD: begin
        if (cnt_q == '0) begin
          lin_nxt = AW'(lin_r + 1'b1);
          if (lin_r == LAST_LIN) begin
            state_nxt = S_FL_RD;
          end else begin
            state_nxt = S_MN_RD;
          end
          if (lin_r == LAST_LIN && passes_r == '0) begin
            state_nxt = S_FDONE;
          end
        end else begin
          col_hold_nxt = col_q;
          dvsr_nxt     = cnt_q;
          neg_nxt      = row_q[39];
          div_q_nxt    = {(row_q[39] ? (40'd0 - row_q) : row_q), 8'd0};
          div_rem_nxt  = '0;
          div_cnt_nxt  = '0;
          state_nxt    = S_DIVR;
        end
        pass_nxt = 6'd1;
        r_nxt    = '0;
        g_nxt    = '0;
        b_nxt    = '0;
      end
      S_DIVR, S_DIVC: begin
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd47) begin
          state_nxt = (state_r == S_DIVR) ? S_ROWEND : S_COLEND;
        end
      end
      S_ROWEND: begin
        row_mean_nxt = mean_finish(div_q_r, neg_r);
        neg_nxt      = col_hold_r[39];
        div_q_nxt    = {(col_hold_r[39] ? (40'd0 - col_hold_r) : col_hold_r), 8'd0};
        div_rem_nxt  = '0;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIVC;
      end
      S_COLEND: begin
        wr_addr = lin_r;
        we_sum  = 1'b1;
        wd_row  = row_mean_r;
        wd_col  = mean_finish(div_q_r, neg_r);
        lin_nxt = AW'(lin_r + 1'b1);
        if (lin_r == LAST_LIN) begin
          state_nxt = (passes_r == '0) ? S_FDONE : S_FL_RD;
        end else begin
          state_nxt = S_MN_RD;
        end
      end
      S_FL_RD: begin
        rd_addr   = here_idx;
        state_nxt = S_FL_CHK;
      end
      S_FL_CHK: begin
        if (cnt_q != '0 || tag_q != '0) begin
          adv_bin = 1'b1;
        end else begin
          k_nxt     = 3'd7;
          state_nxt = S_NB_ADDR;
        end
      end
      S_NB_ADDR: begin
        rd_addr = nb_idx;
        if (nb_in_bounds) begin
          state_nxt = S_NB_CHK;
        end else if (k_r == 3'd0) begin
          adv_bin = 1'b1;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      S_NB_CHK: begin
        // Scan runs backward, so the first usable neighbor is the last in scan order
        if (cnt_q != '0 || (tag_q != '0 && tag_q != pass_r)) begin
          opa_nxt   = row_q[16:0];
          opb_nxt   = col_q[16:0];
          state_nxt = S_MUL_A;
        end else if (k_r == 3'd0) begin
          adv_bin = 1'b1;
        end else begin
          k_nxt     = k_r - 3'd1;
          state_nxt = S_NB_ADDR;
        end
      end
      S_MUL_A: begin
        prod_nxt  = mul_out;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        fill_row_nxt = fill_scale(prod_r);
        prod_nxt     = mul_out;
        state_nxt    = S_FL_WR;
      end
      S_FL_WR: begin
        wr_addr = here_idx;
        we_sum  = 1'b1;
        we_tag  = 1'b1;
        wd_row  = sext_mean(fill_row_r);
        wd_col  = sext_mean(fill_scale(prod_r));
        wd_tag  = pass_r;
        adv_bin = 1'b1;
      end
      S_FDONE: begin
        ready_flag_nxt      = 1'b1;
        res_nxt             = '0;
        res_nxt.kind        = cbgt_pkg::KIND_DONE;
        res_nxt.table_ready = 1'b1;
        state_nxt           = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Step the r,g,b scan; wrap into the next pass or finish
    if (adv_bin) begin
      state_nxt = S_FL_RD;
      if (b_r != LAST_BIN) begin
        b_nxt = CW'(b_r + 1'b1);
      end else begin
        b_nxt = '0;
        if (g_r != LAST_BIN) begin
          g_nxt = CW'(g_r + 1'b1);
        end else begin
          g_nxt = '0;
          r_nxt = (r_r != LAST_BIN) ? CW'(r_r + 1'b1) : '0;
        end
      end
      if (bin_last) begin
        if (pass_r == passes_r) begin
          state_nxt = S_FDONE;
        end else begin
          pass_nxt = pass_r + 6'd1;
        end
      end
    end
  end

  // Stores: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we_sum) begin
      row_mem[wr_addr] <= wd_row;
      col_mem[wr_addr] <= wd_col;
    end
    if (we_cnt) begin
      cnt_mem[wr_addr] <= wd_cnt;
    end
    if (we_tag) begin
      tag_mem[wr_addr] <= wd_tag;
    end
    row_q <= row_mem[rd_addr];
    col_q <= col_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
    tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      lin_r        <= '0;
      ready_flag_r <= 1'b0;
      out_valid_r  <= 1'b0;
      gain_r       <= cbgt_pkg::FILL_GAIN_RESET;
      passes_r     <= cbgt_pkg::FILL_PASSES_RESET;
    end else begin
      state_r      <= state_nxt;
      lin_r        <= lin_nxt;
      ready_flag_r <= ready_flag_nxt;
      if (state_r == S_EMIT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          cbgt_pkg::REG_FILL_GAIN:   gain_r   <= cfg_data;
          cbgt_pkg::REG_FILL_PASSES: passes_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    g_r        <= g_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    pass_r     <= pass_nxt;
    in_r       <= in_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    dvsr_r     <= dvsr_nxt;
    neg_r      <= neg_nxt;
    col_hold_r <= col_hold_nxt;
    row_mean_r <= row_mean_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    prod_r     <= prod_nxt;
    fill_row_r <= fill_row_nxt;
    res_r      <= res_nxt;
    if (state_r == S_EMIT && (!out_valid_r || out_tready)) begin
      out_r <= res_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {7'd0, out_r.filled_in_pass, out_r.sample_total, out_r.col_grad_mean,
                       out_r.row_grad_mean, out_r.table_ready};

`ifndef SYNTHESIS
  // No request enters while the table is being swept or walked
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (state_r == S_IDLE))
    else $error("request accepted outside idle");

  // A new result only leaves the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

  // The table turns ready only at the end of a finalize walk
  a_ready_from_finalize: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_flag_r) |-> ($past(state_r) == S_FDONE))
    else $error("ready flag set outside finalize");

  // The divider never runs past its 48 steps
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVR || state_r == S_DIVC) |-> (div_cnt_r <= 6'd47))
    else $error("divider step count overrun");
`endif

endmodule
